[rtl/gcd_pkg.sv]
`default_nettype none

package gcd_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CORDIC_W = 34;
    localparam int SQRT_STEPS = 32;

    localparam logic signed [23:0] LAT_LIMIT = 24'sd5898240;
    localparam logic signed [24:0] LON_LIMIT = 25'sd11796480;
    localparam logic signed [63:0] Q_ONE = 64'sd1073741824;
    localparam logic signed [63:0] Q_HALF_PI = 64'sd1686629713;
    localparam logic signed [63:0] Q_PI = 64'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] GAIN_INV = 34'sd652032874;
    localparam logic signed [63:0] DEG_RAD_LO = 64'sd502557221;
    localparam logic [22:0] RADIUS_RESET = 23'd6371000;

    function automatic logic signed [CORDIC_W-1:0] step_angle(input int i);
        logic signed [CORDIC_W-1:0] ang;
        ang = '0;
        if (i < 10)
        begin
            unique case (i)
                0: ang = 34'sd843314857;
                1: ang = 34'sd497837829;
                2: ang = 34'sd263043837;
                3: ang = 34'sd133525159;
                4: ang = 34'sd67021687;
                5: ang = 34'sd33543516;
                6: ang = 34'sd16775851;
                7: ang = 34'sd8388437;
                8: ang = 34'sd4194283;
                default: ang = 34'sd2097149;
            endcase
        end
        else if (i <= 30)
        begin
            ang = 34'sd1 <<< (30 - i);
        end
        return ang;
    endfunction

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int s);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [63:0] angle_scale(input logic signed [25:0] d);
        logic signed [63:0] dx;
        dx = 64'(d);
        return (dx <<< 32) + dx * DEG_RAD_LO;
    endfunction

    function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return 32'(round_shift(64'(a) * 64'(b), 30));
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > Q_ONE)
        begin
            res = 32'(Q_ONE);
        end
        else
        begin
            res = 32'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/gcd_delay.sv]
`default_nettype none

module gcd_delay #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] d,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                pipe_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

`default_nettype wire

[rtl/gcd_cordic.sv]
`default_nettype none

module gcd_cordic #(
    parameter int   STAGES    = gcd_pkg::CORDIC_STAGES_DEF,
    parameter bit   VECTORING = 1'b0
) (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [gcd_pkg::CORDIC_W-1:0] x_in,
    input  wire logic signed [gcd_pkg::CORDIC_W-1:0] y_in,
    input  wire logic signed [gcd_pkg::CORDIC_W-1:0] z_in,
    output logic signed      [gcd_pkg::CORDIC_W-1:0] x_out,
    output logic signed      [gcd_pkg::CORDIC_W-1:0] y_out,
    output logic signed      [gcd_pkg::CORDIC_W-1:0] z_out
);

    localparam int W = gcd_pkg::CORDIC_W;

    logic signed [W-1:0] x_reg [STAGES];
    logic signed [W-1:0] y_reg [STAGES];
    logic signed [W-1:0] z_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [W-1:0] x_prev, y_prev, z_prev;
        logic signed [W-1:0] x_next, y_next, z_next;
        logic                rot_pos;

        if (i == 0)
        begin : g_first
            assign x_prev = x_in;
            assign y_prev = y_in;
            assign z_prev = z_in;
        end
        else
        begin : g_rest
            assign x_prev = x_reg[i-1];
            assign y_prev = y_reg[i-1];
            assign z_prev = z_reg[i-1];
        end

        assign rot_pos = VECTORING ? y_prev[W-1] : ~z_prev[W-1];

        always_comb
        begin
            if (rot_pos)
            begin
                x_next = x_prev - (y_prev >>> i);
                y_next = y_prev + (x_prev >>> i);
                z_next = z_prev - gcd_pkg::step_angle(i);
            end
            else
            begin
                x_next = x_prev + (y_prev >>> i);
                y_next = y_prev - (x_prev >>> i);
                z_next = z_prev + gcd_pkg::step_angle(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign x_out = x_reg[STAGES-1];
    assign y_out = y_reg[STAGES-1];
    assign z_out = z_reg[STAGES-1];

endmodule

`default_nettype wire

[rtl/gcd_isqrt.sv]
`default_nettype none

module gcd_isqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] n_in,
    output logic      [31:0] root
);

    localparam int STEPS = gcd_pkg::SQRT_STEPS;

    logic [63:0] n_reg [STEPS];
    logic [63:0] r_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] n_prev, r_prev, trial, n_next, r_next;

        if (k == 0)
        begin : g_first
            assign n_prev = n_in;
            assign r_prev = '0;
        end
        else
        begin : g_rest
            assign n_prev = n_reg[k-1];
            assign r_prev = r_reg[k-1];
        end

        assign trial = r_prev + BIT;

        always_comb
        begin
            if (n_prev >= trial)
            begin
                n_next = n_prev - trial;
                r_next = (r_prev >> 1) + BIT;
            end
            else
            begin
                n_next = n_prev;
                r_next = r_prev >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k] <= n_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[STEPS-1][31:0];

endmodule

`default_nettype wire

[rtl/great_circle_distance.sv]
// Channel  | Handshake                  | Payload
// item     | item_valid, item_ready     | first/second latitude and longitude
// result   | result_valid, result_ready | distance_m, coord_error
// config   | cfg_valid, cfg_ready       | sphere_radius_m
//
// One item is taken every cycle unless a waiting result stalls the pipeline; each result
// passes the rotation CORDIC chains, the 32-step square root and the vectoring CORDIC chain.
// Reset clears the valid bits and sets the radius to 6371000 metres.
// A waiting result stalls the whole pipeline at once; the config port is always ready.
`default_nettype none

module great_circle_distance #(
    parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic signed [23:0] first_latitude,
    input  wire logic signed [24:0] first_longitude,
    input  wire logic signed [23:0] second_latitude,
    input  wire logic signed [24:0] second_longitude,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic             [24:0] distance_m,
    output logic                    coord_error,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [22:0] sphere_radius_m
);

    localparam int W = gcd_pkg::CORDIC_W;

    typedef struct packed {
        logic valid;
        logic err;
    } side_t;

    logic en;
    logic [22:0] radius_reg;

    side_t a_side_reg, b_side_reg, c_side_reg, m1_side_reg, m2_side_reg;
    side_t f_side_reg, g_side_reg;
    side_t sc_side, sq_side, vc_side;

    logic signed [23:0] a_lat1_reg, a_lat2_reg;
    logic signed [24:0] a_dlat_reg;
    logic signed [25:0] a_dlon_reg;
    logic signed [63:0] b_hlat_reg, b_hlon_reg, b_r1_reg, b_r2_reg;
    logic signed [W-1:0] c_hlat_reg, c_hlon_reg, c_r1_reg, c_r2_reg;
    logic signed [63:0] hlat_r, hlon_r, hlon_f;
    logic coord_bad;

    logic signed [W-1:0] sl_s, sn_s, c1_c, c2_c;
    logic signed [31:0] m1_sl2_reg, m1_sn2_reg, m1_c12_reg;
    logic [30:0] m2_a_reg;
    logic [31:0] sy_root, sx_root;
    logic signed [W-1:0] v_z;
    logic [30:0] f_z_reg;
    logic [55:0] dist_prod;
    logic [24:0] g_dist_reg;

    assign en = !g_side_reg.valid || result_ready;
    assign item_ready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= gcd_pkg::RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            radius_reg <= sphere_radius_m;
        end
    end

    assign coord_bad = (first_latitude < -gcd_pkg::LAT_LIMIT)
        || (first_latitude > gcd_pkg::LAT_LIMIT)
        || (second_latitude < -gcd_pkg::LAT_LIMIT)
        || (second_latitude > gcd_pkg::LAT_LIMIT)
        || (first_longitude < -gcd_pkg::LON_LIMIT)
        || (first_longitude > gcd_pkg::LON_LIMIT)
        || (second_longitude < -gcd_pkg::LON_LIMIT)
        || (second_longitude > gcd_pkg::LON_LIMIT);

    always_comb
    begin
        hlat_r = gcd_pkg::round_shift(b_hlat_reg, 25);
        hlon_r = gcd_pkg::round_shift(b_hlon_reg, 25);
        if (hlon_r > gcd_pkg::Q_HALF_PI)
        begin
            hlon_f = hlon_r - gcd_pkg::Q_PI;
        end
        else if (hlon_r < -gcd_pkg::Q_HALF_PI)
        begin
            hlon_f = hlon_r + gcd_pkg::Q_PI;
        end
        else
        begin
            hlon_f = hlon_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_side_reg <= '0;
            b_side_reg <= '0;
            c_side_reg <= '0;
            m1_side_reg <= '0;
            m2_side_reg <= '0;
            f_side_reg <= '0;
            g_side_reg <= '0;
        end
        else if (en)
        begin
            a_side_reg <= '{valid: item_valid, err: coord_bad};
            b_side_reg <= a_side_reg;
            c_side_reg <= b_side_reg;
            m1_side_reg <= sc_side;
            m2_side_reg <= m1_side_reg;
            f_side_reg <= vc_side;
            g_side_reg <= f_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_lat1_reg <= first_latitude;
            a_lat2_reg <= second_latitude;
            a_dlat_reg <= 25'(second_latitude) - 25'(first_latitude);
            a_dlon_reg <= 26'(second_longitude) - 26'(first_longitude);

            b_hlat_reg <= gcd_pkg::angle_scale(26'(a_dlat_reg));
            b_hlon_reg <= gcd_pkg::angle_scale(a_dlon_reg);
            b_r1_reg <= gcd_pkg::angle_scale(26'(a_lat1_reg));
            b_r2_reg <= gcd_pkg::angle_scale(26'(a_lat2_reg));

            c_hlat_reg <= W'(hlat_r);
            c_hlon_reg <= W'(hlon_f);
            c_r1_reg <= W'(gcd_pkg::round_shift(b_r1_reg, 24));
            c_r2_reg <= W'(gcd_pkg::round_shift(b_r2_reg, 24));

            m1_sl2_reg <= gcd_pkg::clamp_unit(64'(gcd_pkg::mul_q(32'(sl_s), 32'(sl_s))));
            m1_sn2_reg <= gcd_pkg::clamp_unit(64'(gcd_pkg::mul_q(32'(sn_s), 32'(sn_s))));
            m1_c12_reg <= gcd_pkg::mul_q(gcd_pkg::clamp_unit(64'(c1_c)),
                                         gcd_pkg::clamp_unit(64'(c2_c)));

            m2_a_reg <= 31'(gcd_pkg::clamp_unit(64'(m1_sl2_reg)
                + 64'(gcd_pkg::mul_q(m1_sn2_reg, m1_c12_reg))));

            if (v_z[W-1])
            begin
                f_z_reg <= '0;
            end
            else if (64'(v_z) > gcd_pkg::Q_HALF_PI)
            begin
                f_z_reg <= 31'(gcd_pkg::Q_HALF_PI);
            end
            else
            begin
                f_z_reg <= 31'(v_z);
            end

            g_dist_reg <= f_side_reg.err ? '0 : dist_prod[53:29];
        end
    end

    assign dist_prod = 56'(radius_reg) * 56'(f_z_reg) + (56'd1 << 28);

    gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_sin_hlat (
        .clk(clk), .en(en),
        .x_in(gcd_pkg::GAIN_INV), .y_in('0), .z_in(c_hlat_reg),
        .x_out(), .y_out(sl_s), .z_out()
    );

    gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_sin_hlon (
        .clk(clk), .en(en),
        .x_in(gcd_pkg::GAIN_INV), .y_in('0), .z_in(c_hlon_reg),
        .x_out(), .y_out(sn_s), .z_out()
    );

    gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_cos_lat1 (
        .clk(clk), .en(en),
        .x_in(gcd_pkg::GAIN_INV), .y_in('0), .z_in(c_r1_reg),
        .x_out(c1_c), .y_out(), .z_out()
    );

    gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_cos_lat2 (
        .clk(clk), .en(en),
        .x_in(gcd_pkg::GAIN_INV), .y_in('0), .z_in(c_r2_reg),
        .x_out(c2_c), .y_out(), .z_out()
    );

    gcd_delay #(.WIDTH($bits(side_t)), .DEPTH(CORDIC_STAGES)) u_sc_delay (
        .clk(clk), .rst_n(rst_n), .en(en), .d(c_side_reg), .q(sc_side)
    );

    gcd_isqrt u_sqrt_a (
        .clk(clk), .en(en), .n_in({3'b0, m2_a_reg, 30'b0}), .root(sy_root)
    );

    gcd_isqrt u_sqrt_b (
        .clk(clk), .en(en),
        .n_in({3'b0, 31'(gcd_pkg::Q_ONE) - m2_a_reg, 30'b0}), .root(sx_root)
    );

    gcd_delay #(.WIDTH($bits(side_t)), .DEPTH(gcd_pkg::SQRT_STEPS)) u_sq_delay (
        .clk(clk), .rst_n(rst_n), .en(en), .d(m2_side_reg), .q(sq_side)
    );

    gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b1)) u_atan (
        .clk(clk), .en(en),
        .x_in(W'(sx_root)), .y_in(W'(sy_root)), .z_in('0),
        .x_out(), .y_out(), .z_out(v_z)
    );

    gcd_delay #(.WIDTH($bits(side_t)), .DEPTH(CORDIC_STAGES)) u_vc_delay (
        .clk(clk), .rst_n(rst_n), .en(en), .d(sq_side), .q(vc_side)
    );

    assign result_valid = g_side_reg.valid;
    assign coord_error = g_side_reg.err;
    assign distance_m = g_dist_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && coord_error |-> distance_m == '0)
        else $error("distance not zero on coordinate error");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("input stalled without a blocked result");

    a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (first_latitude > gcd_pkg::LAT_LIMIT)
        |=> a_side_reg.err && a_side_reg.valid)
        else $error("out of range latitude not flagged");
`endif

endmodule

`default_nettype wire

[test/gcd_checker.sv]
`timescale 1ns / 1ps

module gcd_checker #(
    parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire logic               item_ready,
    input  wire logic signed [23:0] first_latitude,
    input  wire logic signed [24:0] first_longitude,
    input  wire logic signed [23:0] second_latitude,
    input  wire logic signed [24:0] second_longitude,
    input  wire logic               result_valid,
    input  wire logic               result_ready,
    input  wire logic        [24:0] distance_m,
    input  wire logic               coord_error,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic        [22:0] sphere_radius_m,
    output int                      errors,
    output int                      pending
);

    typedef struct packed {
        logic [24:0] metres;
        logic        err;
    } route_t;

    localparam longint LAT_MAX = 5898240;
    localparam longint LON_MAX = 11796480;
    localparam longint UNIT = 64'sd1073741824;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint PI = 64'sd3373259426;
    localparam longint K_INV = 64'sd652032874;
    localparam longint DEG_K = 64'sd4797524517;

    route_t distances_due[$];
    logic [22:0] radius;

    function automatic longint atan_step(input int i);
        longint lo [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return lo[i];
        if (i <= 30)
            return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic longint rnd_shift(input longint v, input int s);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unit_clip(input longint v);
        if (v < 0)
            return 0;
        if (v > UNIT)
            return UNIT;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return rnd_shift(a * b, 30);
    endfunction

    function automatic void rotate(input longint ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = K_INV;
        y = 0;
        z = ang;
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        s = y;
        c = x;
    endfunction

    function automatic longint root60(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        if (z < 0)
            z = 0;
        if (z > HALF_PI)
            z = HALF_PI;
        return z;
    endfunction

    function automatic route_t haversine(input longint la1, input longint lo1,
                                         input longint la2, input longint lo2,
                                         input logic [22:0] rad);
        route_t res;
        longint hlat;
        longint hlon;
        longint r1;
        longint r2;
        longint sl;
        longint sn;
        longint c1;
        longint c2;
        longint t;
        longint a;
        longint z;
        longint unsigned d;
        res = '0;
        if (la1 < -LAT_MAX || la1 > LAT_MAX || la2 < -LAT_MAX || la2 > LAT_MAX ||
            lo1 < -LON_MAX || lo1 > LON_MAX || lo2 < -LON_MAX || lo2 > LON_MAX)
        begin
            res.err = 1'b1;
            return res;
        end
        hlat = rnd_shift((la2 - la1) * DEG_K, 25);
        hlon = rnd_shift((lo2 - lo1) * DEG_K, 25);
        if (hlon > HALF_PI)
            hlon -= PI;
        else if (hlon < -HALF_PI)
            hlon += PI;
        r1 = rnd_shift(la1 * DEG_K, 24);
        r2 = rnd_shift(la2 * DEG_K, 24);
        rotate(hlat, sl, t);
        rotate(hlon, sn, t);
        rotate(r1, t, c1);
        rotate(r2, t, c2);
        c1 = unit_clip(c1);
        c2 = unit_clip(c2);
        sl = unit_clip(qmul(sl, sl));
        sn = unit_clip(qmul(sn, sn));
        a = unit_clip(sl + qmul(sn, qmul(c1, c2)));
        z = vector_angle(root60(longint'(a) << 30), root60(longint'(UNIT - a) << 30));
        d = (longint'(rad) * z + (64'd1 << 28)) >> 29;
        res.metres = d[24:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius <= gcd_pkg::RADIUS_RESET;
            distances_due.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            route_t got;
            route_t want;
            int fails;
            fails = errors;
            if (result_valid && result_ready)
            begin
                got.metres = distance_m;
                got.err = coord_error;
                if (distances_due.size() == 0)
                begin
                    $display("%0t: unexpected result: actual distance %0d error %0b",
                             $time, got.metres, got.err);
                    fails++;
                end
                else
                begin
                    want = distances_due.pop_front();
                    if (got.metres !== want.metres)
                    begin
                        $display("%0t: distance_m mismatch: expected %0d actual %0d",
                                 $time, want.metres, got.metres);
                        fails++;
                    end
                    if (got.err !== want.err)
                    begin
                        $display("%0t: coord_error mismatch: expected %0b actual %0b",
                                 $time, want.err, got.err);
                        fails++;
                    end
                end
            end
            if (item_valid && item_ready)
                distances_due.push_back(haversine(first_latitude, first_longitude,
                                                  second_latitude, second_longitude,
                                                  radius));
            if (cfg_valid && cfg_ready)
                radius <= sphere_radius_m;
            errors <= fails;
            pending <= distances_due.size();
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int LAT = 5898240;
    localparam int LON = 11796480;
    localparam int LIMIT = 600000;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    logic signed [23:0] first_latitude;
    logic signed [24:0] first_longitude;
    logic signed [23:0] second_latitude;
    logic signed [24:0] second_longitude;
    logic               result_valid;
    logic               result_ready;
    logic        [24:0] distance_m;
    logic               coord_error;
    logic               cfg_valid;
    logic               cfg_ready;
    logic        [22:0] sphere_radius_m;
    int                 errors;
    int                 pending;
    int                 cycles;
    bit                 calm;
    bit                 long_hold;

    great_circle_distance DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .first_latitude(first_latitude), .first_longitude(first_longitude),
        .second_latitude(second_latitude), .second_longitude(second_longitude),
        .result_valid(result_valid), .result_ready(result_ready),
        .distance_m(distance_m), .coord_error(coord_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .sphere_radius_m(sphere_radius_m)
    );

    gcd_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .first_latitude(first_latitude), .first_longitude(first_longitude),
        .second_latitude(second_latitude), .second_longitude(second_longitude),
        .result_valid(result_valid), .result_ready(result_ready),
        .distance_m(distance_m), .coord_error(coord_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .sphere_radius_m(sphere_radius_m),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("** great_circle_distance: FAILED **");
                $finish;
            end
        end
    end

    // The receiver stalls in short bursts, or once for a long stretch on request.
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                result_ready = 1'b0;
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_ready = 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
                result_ready = 1'b1;
        end
    end

    task automatic send(input int la1, input int lo1, input int la2, input int lo2);
        bit took;
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        first_latitude = la1[23:0];
        first_longitude = lo1[24:0];
        second_latitude = la2[23:0];
        second_longitude = lo2[24:0];
        item_valid = 1'b1;
        forever
        begin
            #1 took = item_ready;
            @(negedge clk);
            if (took)
                break;
        end
    endtask

    task automatic drain();
        item_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic set_radius(input logic [22:0] r);
        bit took;
        sphere_radius_m = r;
        cfg_valid = 1'b1;
        forever
        begin
            #1 took = cfg_ready;
            @(negedge clk);
            if (took)
                break;
        end
        cfg_valid = 1'b0;
    endtask

    function automatic int pick_coord(input int lim, input int w);
        int v;
        case ($urandom_range(0, 19))
            0:       v = lim + $urandom_range(1, 4000);
            1:       v = -lim - $urandom_range(1, 4000);
            2:       v = $urandom_range(0, (1 << w) - 1) - (1 << (w - 1));
            3:       v = ($urandom_range(0, 1) != 0) ? lim : -lim;
            4:       v = $urandom_range(0, 64) - 32;
            default: v = $urandom_range(0, 2 * lim) - lim;
        endcase
        return v;
    endfunction

    task automatic random_items(input int n);
        int la1;
        int lo1;
        for (int k = 0; k < n; k++)
        begin
            la1 = pick_coord(LAT, 24);
            lo1 = pick_coord(LON, 25);
            if ($urandom_range(0, 4) == 0)
                send(la1, lo1, la1 + $urandom_range(0, 200) - 100,
                     lo1 + $urandom_range(0, 200) - 100);
            else
                send(la1, lo1, pick_coord(LAT, 24), pick_coord(LON, 25));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        first_latitude = '0;
        first_longitude = '0;
        second_latitude = '0;
        second_longitude = '0;
        cfg_valid = 1'b0;
        sphere_radius_m = '0;
        calm = 1'b0;
        long_hold = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(0, 0, 0, 0);
        send(LAT, LON, -LAT, -LON);
        send(-LAT, -LON, LAT, LON);
        send(0, 0, 0, LON);
        send(0, -LON, 0, LON);
        send(LAT, 0, -LAT, 0);
        send(0, 0, 0, LAT);
        send(0, 0, 1, LON);
        send(1, 0, 0, -1);
        send(LAT + 1, 0, 0, 0);
        send(0, 0, -LAT - 1, 0);
        send(0, LON + 1, 0, 0);
        send(0, 0, 0, -LON - 1);
        send(24'h7FFFFF, 0, 0, 0);
        send(-8388608, 0, 0, 0);
        send(0, 25'hFFFFFF, 0, 0);
        send(0, 0, 0, -16777216);
        send(-LAT, LON, LAT, -LON);
        send(LAT, LON, LAT, LON);
        random_items(250);
        drain();

        set_radius(23'd1);
        long_hold = 1'b1;
        random_items(300);
        drain();

        set_radius(23'h7FFFFF);
        random_items(300);
        drain();

        set_radius(23'd0);
        random_items(100);
        drain();

        set_radius(23'($urandom_range(1, 8388607)));
        random_items(300);
        drain();

        set_radius(23'd6371000);
        random_items(250);
        calm = 1'b1;
        random_items(300);
        drain();

        if (errors == 0 && pending == 0)
            $display("** great_circle_distance: PASSED **");
        else
            $display("** great_circle_distance: FAILED **");
        $finish;
    end

endmodule
